### hw/rtl/fpdf_pkg.sv
package fpdf_pkg;

  // packet type codes
  localparam logic [7:0] PKT_HEARTBEAT        = 8'd7;
  localparam logic [7:0] PKT_UNICAST_STRING   = 8'd8;
  localparam logic [7:0] PKT_UNICAST_NUMBER   = 8'd9;
  localparam logic [7:0] PKT_BROADCAST_STRING = 8'd10;
  localparam logic [7:0] PKT_BROADCAST_NUMBER = 8'd11;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_TIME_MS    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_HOPS        = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORWARD_PERCENT = 8'd3;

  // configuration reset values
  localparam logic [31:0] RST_OWN_ADDRESS     = 32'd0;
  localparam logic [15:0] RST_KEEP_TIME_MS    = 16'd7000;
  localparam logic [7:0]  RST_MAX_HOPS        = 8'd1;
  localparam logic [6:0]  RST_FORWARD_PERCENT = 7'd90;

  // delivery codes
  localparam logic [1:0] DELIVER_NONE   = 2'd0;
  localparam logic [1:0] DELIVER_STRING = 2'd1;
  localparam logic [1:0] DELIVER_NUMBER = 2'd2;

  // resend lengths in bytes
  localparam logic [8:0] LEN_HEADER = 9'd11;
  localparam logic [8:0] LEN_STRING = 9'd12;
  localparam logic [8:0] LEN_NUMBER = 9'd15;

  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } fpdf_state_t;

  // token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic go;
    logic hit;
    logic newer;
    logic free_seen;
  } fpdf_token_t;

  // item fields seen by every cell
  typedef struct packed {
    logic        sweep;
    logic [31:0] origin;
    logic [31:0] now_ms;
    logic [7:0]  message_id;
    logic [15:0] keep_time_ms;
  } fpdf_bcast_t;

  // table update strobes
  typedef struct packed {
    logic sweep;
    logic update;
    logic insert;
  } fpdf_commit_t;

endpackage

### hw/rtl/fpdf_cell.sv
module fpdf_cell #(
  parameter int unsigned CNT_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpdf_pkg::fpdf_bcast_t  bcast,
  input  fpdf_pkg::fpdf_commit_t commit,
  input  fpdf_pkg::fpdf_token_t  tok_in,
  input  logic [CNT_W-1:0]     cnt_in,
  output fpdf_pkg::fpdf_token_t  tok_out,
  output logic [CNT_W-1:0]     cnt_out
);

  logic        valid_r;
  logic        valid_nxt;
  logic [31:0] addr_r;
  logic [31:0] seen_r;
  logic [7:0]  id_r;
  logic        first_free_r;
  fpdf_pkg::fpdf_token_t tok_r;
  fpdf_pkg::fpdf_token_t tok_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic        match;
  logic        newer;
  logic        expired;
  logic        counted;
  logic [31:0] expiry;
  logic        take_insert;

  // local compares against the current item
  always_comb begin
    match       = valid_r && (addr_r == bcast.origin);
    newer       = bcast.message_id > id_r;
    expiry      = seen_r + {16'd0, bcast.keep_time_ms};
    expired     = valid_r && (expiry < bcast.now_ms);
    counted     = bcast.sweep ? (valid_r && !expired) : valid_r;
    take_insert = commit.insert && first_free_r;
  end

  // token picks up this cell's findings
  always_comb begin
    tok_nxt.go        = tok_in.go;
    tok_nxt.hit       = tok_in.hit | match;
    tok_nxt.newer     = tok_in.newer | (match && newer);
    tok_nxt.free_seen = tok_in.free_seen | !valid_r;
  end

  // entry valid next value
  always_comb begin
    valid_nxt = valid_r;
    if (commit.sweep && expired) begin
      valid_nxt = 1'b0;
    end
    if (take_insert) begin
      valid_nxt = 1'b1;
    end
  end

  // entry valid state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // token and count hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.go <= 1'b0;
    end else begin
      tok_r.go <= tok_nxt.go;
    end
    if (tok_in.go) begin
      tok_r.hit       <= tok_nxt.hit;
      tok_r.newer     <= tok_nxt.newer;
      tok_r.free_seen <= tok_nxt.free_seen;
      cnt_r           <= cnt_in + CNT_W'(counted);
      first_free_r    <= !valid_r && !tok_in.free_seen;
    end
  end

  // entry contents
  always_ff @(posedge clk) begin
    if (take_insert) begin
      addr_r <= bcast.origin;
      seen_r <= bcast.now_ms;
      id_r   <= bcast.message_id;
    end else if (commit.update && match) begin
      seen_r <= bcast.now_ms;
      id_r   <= bcast.message_id;
    end
  end

  assign tok_out = tok_r;
  assign cnt_out = cnt_r;

endmodule

### hw/rtl/flood_packet_dedup_filter.sv
// Flood packet de-duplication filter. Each input beat is a parsed radio packet
// header or a sweep command and yields exactly one result beat. Sender entries
// live in a row of MEMBER_SLOTS cells; a token walks the row one cell per
// cycle, collecting sender hit, newer-id, first free slot and member count,
// and the table is then updated as the result is issued. A new item is
// accepted only while the block is idle: in_stall is held through the token
// walk through the cell row and while a stalled result waits.
// The table is empty after reset with no clearing pass. Configuration is
// always ready and must be written only while the block is idle.
module flood_packet_dedup_filter #(
  parameter int unsigned MEMBER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_packet_type,
  input  logic [7:0]  in_message_id,
  input  logic [31:0] in_origin_address,
  input  logic [31:0] in_target_address,
  input  logic [7:0]  in_hop_count,
  input  logic [7:0]  in_text_length,
  input  logic        in_name_matches,
  input  logic [6:0]  in_random_percent,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_deliver_kind,
  output logic        out_forward,
  output logic [7:0]  out_forward_hops,
  output logic [8:0]  out_forward_length,
  output logic        out_table_full,
  output logic [4:0]  out_member_count
);

  localparam int unsigned CNT_W = $clog2(MEMBER_SLOTS + 1);
  localparam int unsigned SUM_W = (CNT_W > fpdf_pkg::COUNT_OUT_W) ? CNT_W :
                                  fpdf_pkg::COUNT_OUT_W;

  // configuration registers
  logic [31:0] own_address_r;
  logic [15:0] keep_time_ms_r;
  logic [7:0]  max_hops_r;
  logic [6:0]  forward_percent_r;

  // item registers
  logic        command_r;
  logic [31:0] now_ms_r;
  logic [7:0]  packet_type_r;
  logic [7:0]  message_id_r;
  logic [31:0] origin_r;
  logic [31:0] target_r;
  logic [7:0]  hop_count_r;
  logic [7:0]  text_length_r;
  logic        name_matches_r;
  logic [6:0]  random_percent_r;

  // control
  fpdf_pkg::fpdf_state_t state_r;
  fpdf_pkg::fpdf_state_t state_nxt;
  logic        in_accept;
  logic        out_free;
  logic        fin_go;
  logic        start_r;

  // walk results
  logic             hit_r;
  logic             newer_r;
  logic             free_r;
  logic [CNT_W-1:0] count_r;

  // cell row wiring
  fpdf_pkg::fpdf_token_t  tok   [MEMBER_SLOTS+1];
  logic [CNT_W-1:0]       cnt   [MEMBER_SLOTS+1];
  fpdf_pkg::fpdf_bcast_t  bcast;
  fpdf_pkg::fpdf_commit_t commit;

  // decision logic
  logic        pkt;
  logic        hb;
  logic        insert;
  logic        full;
  logic        data_ok;
  logic        to_me;
  logic        want_fwd;
  logic        fwd;
  logic [1:0]  deliver;
  logic [8:0]  fwd_len;
  logic [SUM_W-1:0] count_sum;

  // result registers
  logic        out_valid_r;
  logic [1:0]  deliver_r;
  logic        forward_r;
  logic [7:0]  forward_hops_r;
  logic [8:0]  forward_length_r;
  logic        table_full_r;
  logic [4:0]  member_count_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != fpdf_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r     <= fpdf_pkg::RST_OWN_ADDRESS;
      keep_time_ms_r    <= fpdf_pkg::RST_KEEP_TIME_MS;
      max_hops_r        <= fpdf_pkg::RST_MAX_HOPS;
      forward_percent_r <= fpdf_pkg::RST_FORWARD_PERCENT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fpdf_pkg::CFG_OWN_ADDRESS:     own_address_r     <= cfg_data;
        fpdf_pkg::CFG_KEEP_TIME_MS:    keep_time_ms_r    <= cfg_data[15:0];
        fpdf_pkg::CFG_MAX_HOPS:        max_hops_r        <= cfg_data[7:0];
        fpdf_pkg::CFG_FORWARD_PERCENT: forward_percent_r <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      command_r        <= in_command;
      now_ms_r         <= in_now_ms;
      packet_type_r    <= in_packet_type;
      message_id_r     <= in_message_id;
      origin_r         <= in_origin_address;
      target_r         <= in_target_address;
      hop_count_r      <= in_hop_count;
      text_length_r    <= in_text_length;
      name_matches_r   <= in_name_matches;
      random_percent_r <= in_random_percent;
    end
  end

  // state register and token launch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpdf_pkg::ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_accept;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    fin_go    = 1'b0;
    unique case (state_r)
      fpdf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fpdf_pkg::ST_WALK;
        end
      end
      fpdf_pkg::ST_WALK: begin
        if (tok[MEMBER_SLOTS].go) begin
          state_nxt = fpdf_pkg::ST_FIN;
        end
      end
      fpdf_pkg::ST_FIN: begin
        if (out_free) begin
          fin_go    = 1'b1;
          state_nxt = fpdf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fpdf_pkg::ST_IDLE;
    endcase
  end

  // broadcast item to the row
  always_comb begin
    bcast.sweep        = command_r;
    bcast.origin       = origin_r;
    bcast.now_ms       = now_ms_r;
    bcast.message_id   = message_id_r;
    bcast.keep_time_ms = keep_time_ms_r;
  end

  // row head
  always_comb begin
    tok[0].go        = start_r;
    tok[0].hit       = 1'b0;
    tok[0].newer     = 1'b0;
    tok[0].free_seen = 1'b0;
    cnt[0]           = '0;
  end

  // cell row
  for (genvar g = 0; g < MEMBER_SLOTS; g++) begin : g_cell
    fpdf_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .bcast  (bcast),
      .commit (commit),
      .tok_in (tok[g]),
      .cnt_in (cnt[g]),
      .tok_out(tok[g+1]),
      .cnt_out(cnt[g+1])
    );
  end

  // latch what the token collected
  always_ff @(posedge clk) begin
    if (tok[MEMBER_SLOTS].go) begin
      hit_r   <= tok[MEMBER_SLOTS].hit;
      newer_r <= tok[MEMBER_SLOTS].newer;
      free_r  <= tok[MEMBER_SLOTS].free_seen;
      count_r <= cnt[MEMBER_SLOTS];
    end
  end

  // packet decision
  always_comb begin
    pkt      = !command_r && (origin_r != own_address_r);
    hb       = pkt && (packet_type_r == fpdf_pkg::PKT_HEARTBEAT) && name_matches_r;
    insert   = hb && !hit_r && free_r;
    full     = hb && !hit_r && !free_r;
    data_ok  = pkt && (packet_type_r != fpdf_pkg::PKT_HEARTBEAT) && hit_r && newer_r;
    to_me    = (target_r == own_address_r);
    want_fwd = 1'b0;
    deliver  = fpdf_pkg::DELIVER_NONE;
    fwd_len  = '0;
    if (hb && (!hit_r || newer_r)) begin
      want_fwd = 1'b1;
      fwd_len  = fpdf_pkg::LEN_HEADER;
    end
    if (data_ok) begin
      case (packet_type_r)
        fpdf_pkg::PKT_UNICAST_STRING: begin
          deliver  = to_me ? fpdf_pkg::DELIVER_STRING : fpdf_pkg::DELIVER_NONE;
          want_fwd = !to_me;
          fwd_len  = fpdf_pkg::LEN_STRING + {1'b0, text_length_r};
        end
        fpdf_pkg::PKT_UNICAST_NUMBER: begin
          deliver  = to_me ? fpdf_pkg::DELIVER_NUMBER : fpdf_pkg::DELIVER_NONE;
          want_fwd = !to_me;
          fwd_len  = fpdf_pkg::LEN_NUMBER;
        end
        fpdf_pkg::PKT_BROADCAST_STRING: begin
          deliver  = fpdf_pkg::DELIVER_STRING;
          want_fwd = 1'b1;
          fwd_len  = fpdf_pkg::LEN_STRING + {1'b0, text_length_r};
        end
        fpdf_pkg::PKT_BROADCAST_NUMBER: begin
          deliver  = fpdf_pkg::DELIVER_NUMBER;
          want_fwd = 1'b1;
          fwd_len  = fpdf_pkg::LEN_NUMBER;
        end
        default: begin
        end
      endcase
    end
    fwd = want_fwd && (hop_count_r < max_hops_r) && (random_percent_r < forward_percent_r);
    count_sum = SUM_W'(count_r) + SUM_W'(insert);
  end

  // table update strobes
  always_comb begin
    commit.sweep  = fin_go && command_r;
    commit.update = fin_go && ((hb && hit_r && newer_r) || data_ok);
    commit.insert = fin_go && insert;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      deliver_r        <= deliver;
      forward_r        <= fwd;
      forward_hops_r   <= fwd ? (hop_count_r + 8'd1) : 8'd0;
      forward_length_r <= fwd ? fwd_len : 9'd0;
      table_full_r     <= full;
      member_count_r   <= count_sum[fpdf_pkg::COUNT_OUT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_deliver_kind   = deliver_r;
  assign out_forward        = forward_r;
  assign out_forward_hops   = forward_hops_r;
  assign out_forward_length = forward_length_r;
  assign out_table_full     = table_full_r;
  assign out_member_count   = member_count_r;

endmodule

### verif/flood_packet_dedup_filter_checker.sv
`timescale 1ns / 1ps
module flood_packet_dedup_filter_checker #(
  parameter int unsigned MEMBER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_now_ms,
  input  logic [7:0]  in_packet_type,
  input  logic [7:0]  in_message_id,
  input  logic [31:0] in_origin_address,
  input  logic [31:0] in_target_address,
  input  logic [7:0]  in_hop_count,
  input  logic [7:0]  in_text_length,
  input  logic        in_name_matches,
  input  logic [6:0]  in_random_percent,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_deliver_kind,
  input  logic        out_forward,
  input  logic [7:0]  out_forward_hops,
  input  logic [8:0]  out_forward_length,
  input  logic        out_table_full,
  input  logic [4:0]  out_member_count,
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    logic [1:0] deliver_kind;
    logic       forward;
    logic [7:0] forward_hops;
    logic [8:0] forward_length;
    logic       table_full;
    logic [4:0] member_count;
  } verdict_t;

  // shadow of the registers
  logic [31:0] own_addr;
  logic [15:0] keep_ms;
  logic [7:0]  hop_limit;
  logic [6:0]  fwd_pct;

  // shadow of the sender table
  logic        known [MEMBER_SLOTS];
  logic [31:0] sender_addr [MEMBER_SLOTS];
  logic [31:0] last_seen [MEMBER_SLOTS];
  logic [7:0]  last_id [MEMBER_SLOTS];

  verdict_t pending_verdicts [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // work out the result of the header beat on the input ports and update the table
  task automatic judge_header(output verdict_t v);
    int          slot;
    int          free_slot;
    int          count;
    logic        fresh;
    logic        want_fwd;
    logic [8:0]  len;
    logic [31:0] expiry;
    v = '0;
    slot = -1;
    free_slot = -1;
    fresh = 1'b0;
    want_fwd = 1'b0;
    len = '0;
    count = 0;
    if (in_command) begin
      // sweep: drop entries whose lifetime ran out
      for (int i = 0; i < MEMBER_SLOTS; i++) begin
        expiry = last_seen[i] + {16'd0, keep_ms};
        if (known[i] && expiry < in_now_ms) known[i] = 1'b0;
      end
    end else if (in_origin_address != own_addr) begin
      // lowest matching and lowest free slot
      for (int i = MEMBER_SLOTS - 1; i >= 0; i--) begin
        if (known[i] && sender_addr[i] == in_origin_address) slot = i;
        if (!known[i]) free_slot = i;
      end
      if (in_packet_type == fpdf_pkg::PKT_HEARTBEAT) begin
        if (in_name_matches) begin
          if (slot < 0) begin
            if (free_slot >= 0) begin
              known[free_slot] = 1'b1;
              sender_addr[free_slot] = in_origin_address;
              last_seen[free_slot] = in_now_ms;
              last_id[free_slot] = in_message_id;
            end else begin
              v.table_full = 1'b1;
            end
            fresh = 1'b1;
          end else if (in_message_id > last_id[slot]) begin
            last_id[slot] = in_message_id;
            last_seen[slot] = in_now_ms;
            fresh = 1'b1;
          end
          if (fresh) begin
            want_fwd = 1'b1;
            len = fpdf_pkg::LEN_HEADER;
          end
        end
      end else if (slot >= 0 && in_message_id > last_id[slot]) begin
        last_id[slot] = in_message_id;
        last_seen[slot] = in_now_ms;
        case (in_packet_type)
          fpdf_pkg::PKT_UNICAST_STRING: begin
            if (in_target_address == own_addr) v.deliver_kind = fpdf_pkg::DELIVER_STRING;
            else want_fwd = 1'b1;
            len = fpdf_pkg::LEN_STRING + {1'b0, in_text_length};
          end
          fpdf_pkg::PKT_UNICAST_NUMBER: begin
            if (in_target_address == own_addr) v.deliver_kind = fpdf_pkg::DELIVER_NUMBER;
            else want_fwd = 1'b1;
            len = fpdf_pkg::LEN_NUMBER;
          end
          fpdf_pkg::PKT_BROADCAST_STRING: begin
            v.deliver_kind = fpdf_pkg::DELIVER_STRING;
            want_fwd = 1'b1;
            len = fpdf_pkg::LEN_STRING + {1'b0, in_text_length};
          end
          fpdf_pkg::PKT_BROADCAST_NUMBER: begin
            v.deliver_kind = fpdf_pkg::DELIVER_NUMBER;
            want_fwd = 1'b1;
            len = fpdf_pkg::LEN_NUMBER;
          end
          default: ;
        endcase
      end
      // resend needs hop budget and a lucky draw
      if (want_fwd && in_hop_count < hop_limit && in_random_percent < fwd_pct) begin
        v.forward = 1'b1;
        v.forward_hops = in_hop_count + 8'd1;
        v.forward_length = len;
      end
    end
    for (int i = 0; i < MEMBER_SLOTS; i++) begin
      if (known[i]) count++;
    end
    v.member_count = 5'(count);
  endtask

  task automatic check_result(input verdict_t want);
    if (out_deliver_kind !== want.deliver_kind)
      flag_mismatch("deliver_kind", 32'(out_deliver_kind), 32'(want.deliver_kind));
    if (out_forward !== want.forward)
      flag_mismatch("forward", 32'(out_forward), 32'(want.forward));
    if (out_forward_hops !== want.forward_hops)
      flag_mismatch("forward_hops", 32'(out_forward_hops), 32'(want.forward_hops));
    if (out_forward_length !== want.forward_length)
      flag_mismatch("forward_length", 32'(out_forward_length), 32'(want.forward_length));
    if (out_table_full !== want.table_full)
      flag_mismatch("table_full", 32'(out_table_full), 32'(want.table_full));
    if (out_member_count !== want.member_count)
      flag_mismatch("member_count", 32'(out_member_count), 32'(want.member_count));
  endtask

  // watch the three channels
  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      own_addr = fpdf_pkg::RST_OWN_ADDRESS;
      keep_ms = fpdf_pkg::RST_KEEP_TIME_MS;
      hop_limit = fpdf_pkg::RST_MAX_HOPS;
      fwd_pct = fpdf_pkg::RST_FORWARD_PERCENT;
      for (int i = 0; i < MEMBER_SLOTS; i++) known[i] = 1'b0;
      pending_verdicts.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (pending_verdicts.size() == 0) flag_mismatch("result beat with none outstanding", 1, 0);
        else check_result(pending_verdicts.pop_front());
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fpdf_pkg::CFG_OWN_ADDRESS:     own_addr = cfg_data;
          fpdf_pkg::CFG_KEEP_TIME_MS:    keep_ms = cfg_data[15:0];
          fpdf_pkg::CFG_MAX_HOPS:        hop_limit = cfg_data[7:0];
          fpdf_pkg::CFG_FORWARD_PERCENT: fwd_pct = cfg_data[6:0];
          default: ;
        endcase
      end
      // header beat
      if (in_valid && !in_stall) begin
        judge_header(v);
        pending_verdicts.insert(pending_verdicts.size(), v);
      end
    end
    pending <= pending_verdicts.size();
  end

endmodule

### verif/flood_packet_dedup_filter_test.sv
`timescale 1ns / 1ps
module flood_packet_dedup_filter_test;

  localparam logic        CMD_PACKET  = 1'b0;
  localparam logic        CMD_SWEEP   = 1'b1;
  localparam int unsigned PEERS       = 24;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam logic [31:0] SENDER_A    = 32'h8000_0001;
  localparam logic [31:0] STRANGER    = 32'h7FFF_FFFE;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [7:0]  packet_type;
    logic [7:0]  message_id;
    logic [31:0] origin;
    logic [31:0] target;
    logic [7:0]  hops;
    logic [7:0]  text_len;
    logic        name_ok;
    logic [6:0]  rnd;
  } header_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [31:0] in_now_ms = '0;
  logic [7:0]  in_packet_type = '0;
  logic [7:0]  in_message_id = '0;
  logic [31:0] in_origin_address = '0;
  logic [31:0] in_target_address = '0;
  logic [7:0]  in_hop_count = '0;
  logic [7:0]  in_text_length = '0;
  logic        in_name_matches = 1'b0;
  logic [6:0]  in_random_percent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_deliver_kind;
  logic        out_forward;
  logic [7:0]  out_forward_hops;
  logic [8:0]  out_forward_length;
  logic        out_table_full;
  logic [4:0]  out_member_count;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // stimulus-side view of the network
  logic [31:0] clock_ms;
  logic [31:0] own_addr;
  logic [31:0] peer_addr [PEERS];
  logic [7:0]  peer_id [PEERS];

  flood_packet_dedup_filter dut (.*);

  flood_packet_dedup_filter_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // one beat on the input channel, idling a random number of cycles in front
  task automatic send_header(input header_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= h.command;
    in_now_ms <= h.now_ms;
    in_packet_type <= h.packet_type;
    in_message_id <= h.message_id;
    in_origin_address <= h.origin;
    in_target_address <= h.target;
    in_hop_count <= h.hops;
    in_text_length <= h.text_len;
    in_name_matches <= h.name_ok;
    in_random_percent <= h.rnd;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic program_regs(input logic [31:0] addr, input logic [15:0] keep,
                              input logic [7:0] hop_max, input logic [6:0] pct);
    logic [7:0]  idx [4];
    logic [31:0] val [4];
    idx = '{fpdf_pkg::CFG_OWN_ADDRESS, fpdf_pkg::CFG_KEEP_TIME_MS, fpdf_pkg::CFG_MAX_HOPS,
            fpdf_pkg::CFG_FORWARD_PERCENT};
    val = '{addr, {16'd0, keep}, {24'd0, hop_max}, {25'd0, pct}};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    own_addr = addr;
  endtask

  function automatic header_t packet_of(input logic [7:0] ptype, input logic [7:0] id,
                                        input logic [31:0] origin, input logic [31:0] target,
                                        input logic [7:0] hops, input logic [7:0] tlen,
                                        input logic name_ok, input logic [6:0] rnd);
    header_t h;
    clock_ms = clock_ms + 32'd10;
    h = '{command: CMD_PACKET, now_ms: clock_ms, packet_type: ptype, message_id: id,
          origin: origin, target: target, hops: hops, text_len: tlen, name_ok: name_ok,
          rnd: rnd};
    return h;
  endfunction

  // sweep with junk in the fields it ignores
  function automatic header_t sweep_at(input logic [31:0] now);
    header_t h;
    h = '{command: CMD_SWEEP, now_ms: now, packet_type: 8'($urandom),
          message_id: 8'($urandom), origin: $urandom, target: $urandom,
          hops: 8'($urandom), text_len: 8'($urandom), name_ok: 1'($urandom),
          rnd: 7'($urandom_range(99))};
    return h;
  endfunction

  function automatic header_t next_random_header();
    header_t     h;
    int unsigned pick;
    int unsigned p;
    pick = $urandom_range(99);
    p = $urandom_range(PEERS - 1);
    if ($urandom_range(99) < 3) clock_ms = clock_ms + $urandom_range(0, 20000);
    else clock_ms = clock_ms + $urandom_range(0, 600);
    h = sweep_at(clock_ms);
    h.command = CMD_PACKET;
    if ($urandom_range(99) < 70) h.hops = 8'($urandom_range(0, 4));
    if (pick < 8) begin
      h.command = CMD_SWEEP;
    end else if (pick < 32) begin
      // heartbeat from a peer, id mostly moving on
      peer_id[p] = peer_id[p] + 8'($urandom_range(0, 2));
      h.packet_type = fpdf_pkg::PKT_HEARTBEAT;
      h.origin = peer_addr[p];
      h.message_id = peer_id[p];
      h.name_ok = ($urandom_range(9) != 0);
    end else if (pick < 80) begin
      // data from a peer, addressed to us about half the time
      peer_id[p] = peer_id[p] + 8'($urandom_range(0, 3));
      h.packet_type = fpdf_pkg::PKT_UNICAST_STRING + 8'($urandom_range(0, 3));
      h.origin = peer_addr[p];
      h.message_id = peer_id[p];
      case ($urandom_range(3))
        0, 1: h.target = own_addr;
        2: h.target = peer_addr[$urandom_range(PEERS - 1)];
        default: ;
      endcase
    end else if (pick < 86) begin
      // our own packet coming back
      h.origin = own_addr;
      h.packet_type = fpdf_pkg::PKT_HEARTBEAT + 8'($urandom_range(0, 4));
    end else if (pick < 92) begin
      // odd type from a peer
      peer_id[p] = peer_id[p] + 8'($urandom_range(1, 3));
      h.origin = peer_addr[p];
      h.message_id = peer_id[p];
    end
    return h;
  endfunction

  task automatic run_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_header(next_random_header());
      if ($urandom_range(199) == 0) settle();
    end
  endtask

  task automatic run_directed();
    logic [31:0] mark;
    // heartbeat with a foreign group name
    send_header(packet_of(fpdf_pkg::PKT_HEARTBEAT, 8'd9, SENDER_A, 32'd0, 8'd0, 8'd0, 1'b0,
                          7'd0));
    // new sender, resent
    send_header(packet_of(fpdf_pkg::PKT_HEARTBEAT, 8'd0, SENDER_A, 32'd0, 8'd0, 8'd0, 1'b1,
                          7'd0));
    // same id again
    send_header(packet_of(fpdf_pkg::PKT_HEARTBEAT, 8'd0, SENDER_A, 32'd0, 8'd0, 8'd0, 1'b1,
                          7'd0));
    // unicast to us, then unicast elsewhere, one string at the longest length
    send_header(packet_of(fpdf_pkg::PKT_UNICAST_STRING, 8'd1, SENDER_A, own_addr, 8'd0, 8'd5,
                          1'b0, 7'd0));
    send_header(packet_of(fpdf_pkg::PKT_UNICAST_NUMBER, 8'd2, SENDER_A, 32'hFFFF_FFFF, 8'd0,
                          8'd0, 1'b1, 7'd89));
    send_header(packet_of(fpdf_pkg::PKT_UNICAST_STRING, 8'd3, SENDER_A, STRANGER, 8'd0,
                          8'd255, 1'b0, 7'd0));
    // broadcast blocked by hop count and draw
    send_header(packet_of(fpdf_pkg::PKT_BROADCAST_STRING, 8'd4, SENDER_A, 32'd0, 8'd255,
                          8'd0, 1'b1, 7'd99));
    // unknown type still refreshes the entry
    send_header(packet_of(8'hFF, 8'd5, SENDER_A, 32'd0, 8'd0, 8'd0, 1'b0, 7'd0));
    send_header(packet_of(fpdf_pkg::PKT_BROADCAST_NUMBER, 8'd255, SENDER_A, 32'd0, 8'd0,
                          8'd0, 1'b0, 7'd89));
    // data from a sender never seen
    send_header(packet_of(fpdf_pkg::PKT_UNICAST_NUMBER, 8'd200, STRANGER, own_addr, 8'd0,
                          8'd0, 1'b1, 7'd0));
    // our own broadcast
    send_header(packet_of(fpdf_pkg::PKT_BROADCAST_STRING, 8'd1, own_addr, 32'd0, 8'd0, 8'd7,
                          1'b1, 7'd0));
    // fill the table
    for (int i = 0; i < 15; i++) begin
      send_header(packet_of(fpdf_pkg::PKT_HEARTBEAT, 8'(i), 32'hC000_0000 + 32'(i), 32'd0,
                            8'd0, 8'd0, 1'b1, 7'(i)));
    end
    mark = clock_ms;
    // one more sender with no room left
    send_header(packet_of(fpdf_pkg::PKT_HEARTBEAT, 8'd0, 32'h0F0F_0F0F, 32'd0, 8'd0, 8'd0,
                          1'b1, 7'd0));
    // expiry boundary: the latest entry survives the first sweep only
    send_header(sweep_at(mark + 32'd7000));
    send_header(sweep_at(mark + 32'd7001));
    clock_ms = mark + 32'd7001;
  endtask

  initial begin
    for (int p = 0; p < PEERS; p++) begin
      peer_addr[p] = $urandom;
      peer_id[p] = 8'($urandom);
    end
    clock_ms = 32'd1000;
    own_addr = fpdf_pkg::RST_OWN_ADDRESS;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, slow receiver
    send_idle_pct = 21;
    recv_stall_pct = 73;
    run_directed();
    settle();

    // wide open forwarding, slow receiver
    program_regs($urandom, 16'hFFFF, 8'hFF, 7'd100);
    run_random(500);
    settle();

    // everything closed, slow sender
    send_idle_pct = 73;
    recv_stall_pct = 21;
    program_regs(32'hFFFF_FFFF, 16'd0, 8'd0, 7'd0);
    run_random(250);
    settle();

    // time wraps through zero
    clock_ms = 32'hFFFF_C000;
    program_regs(32'd0, 16'd3000, 8'd2, 7'd50);
    run_random(350);
    settle();

    // no idling at all
    send_idle_pct = 0;
    recv_stall_pct = 0;
    program_regs($urandom, 16'd7000, 8'd1, 7'd90);
    run_random(750);
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/fpdf_pkg.sv
hw/rtl/fpdf_cell.sv
hw/rtl/flood_packet_dedup_filter.sv
verif/flood_packet_dedup_filter_checker.sv
verif/flood_packet_dedup_filter_test.sv
